// ----- sv/ebr_pkg.sv -----
// Shared constants and types for the ellipse boundary radius block.
package ebr_pkg;

  localparam int CORDIC_STEPS = 28;
  // Signed datapath width of the rotation stages.
  localparam int CW = 34;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Arctangent of 2^-i in units of 2^32 per turn.
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HALF_WIDTH  = 2'd0,
    REG_HALF_HEIGHT = 2'd1
  } cfg_reg_e;

endpackage

// ----- sv/ebr_cordic.sv -----
// Pipelined CORDIC rotation giving quadrant-folded |cos| and |sin| in Q30.
module ebr_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic                  valid_o,
  output logic [30:0]           cos_o,
  output logic [30:0]           sin_o
);
  import ebr_pkg::*;

  logic                 vld_q [CORDIC_STEPS+1];
  logic                 odd_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] x_q   [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_q   [CORDIC_STEPS+1];
  logic signed [CW-1:0] z_q   [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= signed'({{(CW-30){1'b0}}, angle_i[ANGLE_BITS-3:0],
                           {(32-ANGLE_BITS){1'b0}}});
      odd_q[0] <= angle_i[ANGLE_BITS-2];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy, da;
    // Arithmetic shifts round towards minus infinity, as the rotation requires.
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign da = signed'({{(CW-32){1'b0}}, ATAN_TURNS[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        odd_q[i+1] <= odd_q[i];
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - da;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + da;
        end
      end
    end
  end

  logic [CW-1:0] ax, ay;
  logic [30:0]   cx, cy;
  logic          valid_q;
  logic [30:0]   cos_q, sin_q;

  assign ax = x_q[CORDIC_STEPS][CW-1] ? unsigned'(-x_q[CORDIC_STEPS])
                                      : unsigned'(x_q[CORDIC_STEPS]);
  assign ay = y_q[CORDIC_STEPS][CW-1] ? unsigned'(-y_q[CORDIC_STEPS])
                                      : unsigned'(y_q[CORDIC_STEPS]);
  assign cx = (ax > {{(CW-31){1'b0}}, ONE_Q30}) ? ONE_Q30 : ax[30:0];
  assign cy = (ay > {{(CW-31){1'b0}}, ONE_Q30}) ? ONE_Q30 : ay[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vld_q[CORDIC_STEPS];
    end
  end

  // Odd quadrants swap the roles of cosine and sine.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= odd_q[CORDIC_STEPS] ? cy : cx;
      sin_q <= odd_q[CORDIC_STEPS] ? cx : cy;
    end
  end

  assign valid_o = valid_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

// ----- sv/ebr_hypot.sv -----
// Axis products, normalising shift, squares and pipelined integer square root.
module ebr_hypot #(
  parameter int LENGTH_BITS = 16,
  localparam int SW = $clog2(LENGTH_BITS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [30:0]            cos_i,
  input  logic [30:0]            sin_i,
  input  logic [LENGTH_BITS-1:0] half_width_i,
  input  logic [LENGTH_BITS-1:0] half_height_i,
  output logic                   valid_o,
  output logic [31:0]            hyp_o,
  output logic [SW-1:0]          shift_o
);
  localparam int L  = LENGTH_BITS;
  localparam int UW = L + 31;

  // Index 0 is the product stage, then one stage per possible shift.
  logic          nval_q [L+1];
  logic [UW-1:0] nu_q   [L+1];
  logic [UW-1:0] nv_q   [L+1];
  logic [SW-1:0] ns_q   [L+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nval_q[0] <= 1'b0;
    end else if (en_i) begin
      nval_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nu_q[0] <= {{31{1'b0}}, half_height_i} * {{L{1'b0}}, cos_i};
      nv_q[0] <= {{31{1'b0}}, half_width_i} * {{L{1'b0}}, sin_i};
      ns_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < L; j++) begin : g_norm
    logic [UW-1:0] w;
    assign w = nu_q[j] | nv_q[j];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nval_q[j+1] <= 1'b0;
      end else if (en_i) begin
        nval_q[j+1] <= nval_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (|w[UW-1:31]) begin
          nu_q[j+1] <= nu_q[j] >> 1;
          nv_q[j+1] <= nv_q[j] >> 1;
          ns_q[j+1] <= ns_q[j] + SW'(1);
        end else begin
          nu_q[j+1] <= nu_q[j];
          nv_q[j+1] <= nv_q[j];
          ns_q[j+1] <= ns_q[j];
        end
      end
    end
  end

  logic [30:0]   us, vs;
  logic          sqval_q;
  logic [61:0]   squ_q, sqv_q;
  logic [SW-1:0] sqs_q;

  assign us = nu_q[L][30:0];
  assign vs = nv_q[L][30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqval_q <= 1'b0;
    end else if (en_i) begin
      sqval_q <= nval_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      squ_q <= {31'b0, us} * {31'b0, us};
      sqv_q <= {31'b0, vs} * {31'b0, vs};
      sqs_q <= ns_q[L];
    end
  end

  // Index 0 holds the sum of squares; each later stage settles one root bit.
  logic          rval_q [33];
  logic [63:0]   rn_q   [33];
  logic [63:0]   rr_q   [33];
  logic [SW-1:0] rs_q   [33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rval_q[0] <= 1'b0;
    end else if (en_i) begin
      rval_q[0] <= sqval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rn_q[0] <= {2'b0, squ_q} + {2'b0, sqv_q};
      rr_q[0] <= '0;
      rs_q[0] <= sqs_q;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    assign trial = rr_q[k] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rval_q[k+1] <= 1'b0;
      end else if (en_i) begin
        rval_q[k+1] <= rval_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rs_q[k+1] <= rs_q[k];
        if (rn_q[k] >= trial) begin
          rn_q[k+1] <= rn_q[k] - trial;
          rr_q[k+1] <= (rr_q[k] >> 1) + BIT;
        end else begin
          rn_q[k+1] <= rn_q[k];
          rr_q[k+1] <= rr_q[k] >> 1;
        end
      end
    end
  end

  assign valid_o = rval_q[32];
  assign hyp_o   = rr_q[32][31:0];
  assign shift_o = rs_q[32];

endmodule

// ----- sv/ebr_divide.sv -----
// Pipelined restoring division of the scaled axis product by the hypotenuse.
module ebr_divide #(
  parameter int LENGTH_BITS = 16,
  localparam int SW = $clog2(LENGTH_BITS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [31:0]            hyp_i,
  input  logic [SW-1:0]          shift_i,
  input  logic [LENGTH_BITS-1:0] half_width_i,
  input  logic [LENGTH_BITS-1:0] half_height_i,
  output logic                   valid_o,
  output logic [LENGTH_BITS:0]   quot_o,
  output logic                   ovf_o,
  output logic                   hzero_o
);
  localparam int L  = LENGTH_BITS;
  localparam int NW = 2*L + 31;

  // The user must change the half-axes only while the pipeline is empty; this block leaves that to the user.
  logic [2*L-1:0] ab_q;
  always_ff @(posedge clk_i) begin
    ab_q <= {{L{1'b0}}, half_width_i} * {{L{1'b0}}, half_height_i};
  end

  logic          val0_q;
  logic [NW-1:0] num_q;
  logic [31:0]   h0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val0_q <= 1'b0;
    end else if (en_i) begin
      val0_q <= valid_i;
    end
  end

  // a*b scaled by 2^(31-s).
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= {ab_q, 31'b0} >> shift_i;
      h0_q  <= hyp_i;
    end
  end

  logic [L+29:0] hi;
  assign hi = num_q[NW-1:L+1];

  logic          dval_q [L+2];
  logic [31:0]   dr_q   [L+2];
  logic [L:0]    dq_q   [L+2];
  logic [L:0]    dl_q   [L+2];
  logic [31:0]   dh_q   [L+2];
  logic          dovf_q [L+2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dval_q[0] <= 1'b0;
    end else if (en_i) begin
      dval_q[0] <= val0_q;
    end
  end

  // A quotient past L+1 bits clamps to the larger half-axis unless the hypotenuse is zero.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dovf_q[0] <= hi >= {{(L-2){1'b0}}, h0_q};
      dr_q[0]   <= hi[31:0];
      dl_q[0]   <= num_q[L:0];
      dq_q[0]   <= '0;
      dh_q[0]   <= h0_q;
    end
  end

  for (genvar k = 0; k <= L; k++) begin : g_div
    logic [32:0] r2, diff;
    logic        ge;
    assign r2   = {dr_q[k], dl_q[k][L-k]};
    assign diff = r2 - {1'b0, dh_q[k]};
    assign ge   = r2 >= {1'b0, dh_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dval_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dval_q[k+1] <= dval_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[k+1]   <= ge ? diff[31:0] : r2[31:0];
        dq_q[k+1]   <= {dq_q[k][L-1:0], ge};
        dl_q[k+1]   <= dl_q[k];
        dh_q[k+1]   <= dh_q[k];
        dovf_q[k+1] <= dovf_q[k];
      end
    end
  end

  assign valid_o = dval_q[L+1];
  assign quot_o  = dq_q[L+1];
  assign ovf_o   = dovf_q[L+1];
  assign hzero_o = (dh_q[L+1] == '0);

endmodule

// ----- sv/ellipse_boundary_radius_core.sv -----
// Ellipse boundary radius: top level with configuration, pipeline and output register.
//
// Each angle word gives one radius word: the distance from the centre to the
// boundary of the ellipse set by half_width and half_height, rounded and never
// above the larger half-axis, and zero when either half-axis is zero. A new
// angle is taken every clock cycle while the output word is not stalled; the
// pipeline contains the 28 CORDIC rotation stages, one normalising stage per
// length bit, the 32-stage square root and one divider stage per quotient
// bit. The whole pipeline holds while the output word is stalled. Write the
// half-axes only while no word is in flight.
module ellipse_boundary_radius_core #(
  parameter int ANGLE_BITS  = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ANGLE_BITS-1:0]            angle_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [LENGTH_BITS-1:0]           radius_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ebr_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [LENGTH_BITS-1:0]           cfg_data_i
);
  import ebr_pkg::*;

  localparam int L  = LENGTH_BITS;
  localparam int SW = $clog2(LENGTH_BITS + 1);

  logic [L-1:0] half_width_q, half_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= '0;
      half_height_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HALF_WIDTH:  half_width_q  <= cfg_data_i;
        REG_HALF_HEIGHT: half_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_q;
  logic [L-1:0] radius_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  logic        c_valid;
  logic [30:0] c_cos, c_sin;

  ebr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .angle_i (angle_i),
    .valid_o (c_valid),
    .cos_o   (c_cos),
    .sin_o   (c_sin)
  );

  logic          h_valid;
  logic [31:0]   h_hyp;
  logic [SW-1:0] h_shift;

  ebr_hypot #(.LENGTH_BITS(L)) u_hypot (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (c_valid),
    .cos_i         (c_cos),
    .sin_i         (c_sin),
    .half_width_i  (half_width_q),
    .half_height_i (half_height_q),
    .valid_o       (h_valid),
    .hyp_o         (h_hyp),
    .shift_o       (h_shift)
  );

  logic       d_valid, d_ovf, d_hzero;
  logic [L:0] d_quot;

  ebr_divide #(.LENGTH_BITS(L)) u_divide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (h_valid),
    .hyp_i         (h_hyp),
    .shift_i       (h_shift),
    .half_width_i  (half_width_q),
    .half_height_i (half_height_q),
    .valid_o       (d_valid),
    .quot_o        (d_quot),
    .ovf_o         (d_ovf),
    .hzero_o       (d_hzero)
  );

  logic [L+1:0] q_inc;
  logic [L:0]   rnd;
  logic [L-1:0] big;
  logic         zero_axis;
  logic [L-1:0] radius_d;

  assign q_inc     = {1'b0, d_quot} + (L+2)'(1);
  assign rnd       = q_inc[L+1:1];
  assign big       = (half_width_q > half_height_q) ? half_width_q : half_height_q;
  assign zero_axis = (half_width_q == '0) || (half_height_q == '0);

  always_comb begin
    priority if (zero_axis || d_hzero) begin
      radius_d = '0;
    end else if (d_ovf || (rnd > {1'b0, big})) begin
      radius_d = big;
    end else begin
      radius_d = rnd[L-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      radius_q <= radius_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign radius_o    = radius_q;

  a_radius_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> radius_o <= big)
    else $error("radius above the larger half-axis");

  a_zero_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_axis |-> radius_o == '0)
    else $error("nonzero radius with a zero half-axis");

  a_cfg_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == REG_HALF_WIDTH |=> half_width_q == $past(cfg_data_i))
    else $error("half-width write not taken");

endmodule
